### rtl/core/lzss_hmf_pkg.sv
// Package for the LZSS hash chain match finder.
// Holds sizes, op, link and micro-op codes, controller/datapath structs and helpers.
// No dependencies.
package lzss_hmf_pkg;

	localparam int WinMax      = 4096;
	localparam int MatchMax    = 256;
	localparam int HashEntries = 32768;

	localparam int POS_W  = $clog2(WinMax);
	localparam int WSZ_W  = POS_W + 1;
	localparam int LEN_W  = $clog2(MatchMax) + 1;
	localparam int HASH_W = $clog2(HashEntries);
	localparam int PREV_W = HASH_W + 2;
	localparam int LINK_W = POS_W + 1;

	// Transaction op codes
	localparam logic [1:0] OP_RESET   = 2'd0;
	localparam logic [1:0] OP_PRELOAD = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_SEARCH  = 2'd3;

	// Back link kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_HEAD = 2'd1;
	localparam logic [1:0] KIND_NODE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_MAXLEN  = 1'b1;

	// Datapath micro-ops
	localparam logic [4:0] UOP_NOP      = 5'd0;
	localparam logic [4:0] UOP_LATCH    = 5'd1;
	localparam logic [4:0] UOP_INIT     = 5'd2;
	localparam logic [4:0] UOP_CLEAR    = 5'd3;
	localparam logic [4:0] UOP_PRELOAD  = 5'd4;
	localparam logic [4:0] UOP_UNL_RD   = 5'd5;
	localparam logic [4:0] UOP_UNL_WR1  = 5'd6;
	localparam logic [4:0] UOP_UNL_WR2  = 5'd7;
	localparam logic [4:0] UOP_WBYTE    = 5'd8;
	localparam logic [4:0] UOP_HASH     = 5'd9;
	localparam logic [4:0] UOP_HEAD_RD  = 5'd10;
	localparam logic [4:0] UOP_LINK1    = 5'd11;
	localparam logic [4:0] UOP_LINK2    = 5'd12;
	localparam logic [4:0] UOP_STEP     = 5'd13;
	localparam logic [4:0] UOP_S_START  = 5'd14;
	localparam logic [4:0] UOP_S_NEXT   = 5'd15;
	localparam logic [4:0] UOP_S_CAP    = 5'd16;
	localparam logic [4:0] UOP_CMP      = 5'd17;
	localparam logic [4:0] UOP_EVAL     = 5'd18;
	localparam logic [4:0] UOP_LOAD_OUT = 5'd19;

	typedef struct packed {
		logic [4:0] uop;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       reg_pos;
		logic       hash_done;
		logic       clr_last;
		logic       unl_linked;
		logic       unl_has;
		logic       chain_end;
		logic       cmp_done;
		logic       eval_full;
		logic       out_free;
	} dp_status_t;

	// Ring address pos + k, wrapped once at the window size
	function automatic logic [POS_W-1:0] ring_add(input logic [POS_W-1:0] pos,
			input logic [LEN_W-1:0] k, input logic [WSZ_W-1:0] w);
		logic [WSZ_W-1:0] s;
		s = {1'b0, pos} + WSZ_W'(k);
		if (s >= w) begin
			s = s - w;
		end
		return s[POS_W-1:0];
	endfunction

	// Hash contribution of byte idx of the four hashed bytes
	function automatic logic [HASH_W-1:0] hash_term(input logic [1:0] idx,
			input logic [7:0] b);
		logic [HASH_W-1:0] t;
		case (idx)
			2'd0: t = HASH_W'(b);
			2'd1: t = HASH_W'({b, 3'b0});
			2'd2: t = HASH_W'({b, 5'b0});
			default: t = HASH_W'({b, 7'b0});
		endcase
		return t;
	endfunction

	function automatic logic [WSZ_W-1:0] clamp_win(input logic [WSZ_W-1:0] ws);
		logic [WSZ_W-1:0] w;
		w = ws;
		if (ws < WSZ_W'(16)) begin
			w = WSZ_W'(16);
		end else if (ws > WSZ_W'(WinMax)) begin
			w = WSZ_W'(WinMax);
		end
		return w;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] ml,
			input logic [WSZ_W-1:0] w);
		logic [LEN_W-1:0] l;
		logic [WSZ_W-1:0] half;
		l = ml;
		half = w >> 1;
		if (ml < LEN_W'(4)) begin
			l = LEN_W'(4);
		end else if (ml > LEN_W'(MatchMax)) begin
			l = LEN_W'(MatchMax);
		end
		if ({1'b0, w} < {l, 1'b0}) begin
			l = LEN_W'(half - WSZ_W'(1));
		end
		return l;
	endfunction

endpackage

### rtl/core/lzss_hmf_ctl.sv
// Controller of the LZSS hash chain match finder.
// Sequences datapath micro-ops per transaction; uses lzss_hmf_pkg.
module lzss_hmf_ctl
	import lzss_hmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t sts,
	output ctl_cmd_t   cmd
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_DISP    = 5'd1;
	localparam logic [4:0] ST_INIT    = 5'd2;
	localparam logic [4:0] ST_CLEAR   = 5'd3;
	localparam logic [4:0] ST_PRELOAD = 5'd4;
	localparam logic [4:0] ST_URD     = 5'd5;
	localparam logic [4:0] ST_UWR1    = 5'd6;
	localparam logic [4:0] ST_UWR2    = 5'd7;
	localparam logic [4:0] ST_WBYTE   = 5'd8;
	localparam logic [4:0] ST_HASH    = 5'd9;
	localparam logic [4:0] ST_HEADRD  = 5'd10;
	localparam logic [4:0] ST_LINK1   = 5'd11;
	localparam logic [4:0] ST_LINK2   = 5'd12;
	localparam logic [4:0] ST_STEP    = 5'd13;
	localparam logic [4:0] ST_SSTART  = 5'd14;
	localparam logic [4:0] ST_STEST   = 5'd15;
	localparam logic [4:0] ST_SNEXT   = 5'd16;
	localparam logic [4:0] ST_SCAP    = 5'd17;
	localparam logic [4:0] ST_CMP     = 5'd18;
	localparam logic [4:0] ST_EVAL    = 5'd19;
	localparam logic [4:0] ST_FIN     = 5'd20;

	logic [4:0] state_q, state_d;
	logic       boot_q;
	logic [4:0] after_unl;

	assign in_stall = (state_q != ST_IDLE);
	assign after_unl = (sts.op == OP_SEARCH) ? ST_FIN : ST_WBYTE;

	// Next state and micro-op
	always_comb begin
		state_d = state_q;
		cmd.uop = UOP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.uop = UOP_LATCH;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.op)
					OP_RESET:   state_d = ST_INIT;
					OP_PRELOAD: state_d = ST_PRELOAD;
					OP_ADVANCE: state_d = ST_URD;
					default:    state_d = ST_HASH;
				endcase
			end
			ST_INIT: begin
				cmd.uop = UOP_INIT;
				state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				cmd.uop = UOP_CLEAR;
				if (sts.clr_last) begin
					state_d = boot_q ? ST_IDLE : ST_FIN;
				end
			end
			ST_PRELOAD: begin
				cmd.uop = UOP_PRELOAD;
				state_d = ST_FIN;
			end
			ST_URD: begin
				cmd.uop = UOP_UNL_RD;
				state_d = ST_UWR1;
			end
			ST_UWR1: begin
				cmd.uop = UOP_UNL_WR1;
				state_d = (sts.unl_linked && sts.unl_has) ? ST_UWR2 : after_unl;
			end
			ST_UWR2: begin
				cmd.uop = UOP_UNL_WR2;
				state_d = after_unl;
			end
			ST_WBYTE: begin
				cmd.uop = UOP_WBYTE;
				state_d = sts.reg_pos ? ST_HASH : ST_STEP;
			end
			ST_HASH: begin
				cmd.uop = UOP_HASH;
				if (sts.hash_done) begin
					state_d = ST_HEADRD;
				end
			end
			ST_HEADRD: begin
				cmd.uop = UOP_HEAD_RD;
				state_d = (sts.op == OP_SEARCH) ? ST_SSTART : ST_LINK1;
			end
			ST_LINK1: begin
				cmd.uop = UOP_LINK1;
				state_d = ST_LINK2;
			end
			ST_LINK2: begin
				cmd.uop = UOP_LINK2;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.uop = UOP_STEP;
				state_d = ST_FIN;
			end
			ST_SSTART: begin
				cmd.uop = UOP_S_START;
				state_d = ST_STEST;
			end
			ST_STEST: begin
				state_d = sts.chain_end ? ST_FIN : ST_SNEXT;
			end
			ST_SNEXT: begin
				cmd.uop = UOP_S_NEXT;
				state_d = ST_SCAP;
			end
			ST_SCAP: begin
				cmd.uop = UOP_S_CAP;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.uop = UOP_CMP;
				if (sts.cmp_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.uop = UOP_EVAL;
				state_d = sts.eval_full ? ST_URD : ST_STEST;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.uop = UOP_LOAD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register; boot starts with the chain clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && sts.clr_last) begin
				boot_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/lzss_hmf_dp.sv
// Datapath of the LZSS hash chain match finder: window ring, chain memories,
// pointers, hash, compare and result registers; uses lzss_hmf_pkg.
module lzss_hmf_dp
	import lzss_hmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output dp_status_t        sts,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WSZ_W-1:0]  cfg_data,
	input  logic [1:0]        op,
	input  logic [7:0]        data_byte,
	input  logic              register_position,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LEN_W-1:0]  match_length,
	output logic [WSZ_W-1:0]  match_offset
);

	// Memories
	logic [7:0]        win_mem  [WinMax];
	logic [LINK_W-1:0] head_mem [HashEntries];
	logic [LINK_W-1:0] next_mem [WinMax];
	logic [PREV_W-1:0] prev_mem [WinMax];

	// Registers
	logic [WSZ_W-1:0]  ws_q, w_q;
	logic [LEN_W-1:0]  ml_q, l_q;
	logic [POS_W-1:0]  ins_q, del_q;
	logic [LEN_W-1:0]  pre_q;
	logic [HASH_W-1:0] clr_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [WSZ_W-1:0]  out_ofs_q;
	logic [1:0]        op_q;
	logic [7:0]        byte_q;
	logic              reg_q;
	logic [2:0]        hk_q;
	logic [HASH_W-1:0] h_q;
	logic [POS_W-1:0]  cur_q, here_q;
	logic              cur_v_q;
	logic [WSZ_W-1:0]  steps_q;
	logic [LEN_W-1:0]  k_q, len_q, best_q;
	logic              pend_q;
	logic [WSZ_W-1:0]  bo_q;
	logic [7:0]        win_rd_a_q, win_rd_b_q;
	logic [LINK_W-1:0] head_rd_q, next_rd_q;
	logic [PREV_W-1:0] prev_rd_q;

	// Memory port controls
	logic              win_we;
	logic [POS_W-1:0]  win_wa, win_ra_a, win_ra_b;
	logic [7:0]        win_wd;
	logic              head_we, head_re;
	logic [HASH_W-1:0] head_wa;
	logic [LINK_W-1:0] head_wd;
	logic              next_we, next_re;
	logic [POS_W-1:0]  next_wa, next_ra;
	logic [LINK_W-1:0] next_wd;
	logic              prev_we, prev_re;
	logic [POS_W-1:0]  prev_wa;
	logic [PREV_W-1:0] prev_wd;

	logic [POS_W-1:0]  unl_p;
	logic [1:0]        unl_kind;
	logic [WSZ_W-1:0]  eval_ofs;
	logic [LEN_W-1:0]  eval_len;
	logic              eval_take;
	logic              cmp_mism;
	logic [WSZ_W-1:0]  init_w;
	logic [LEN_W-1:0]  init_l;
	logic              clr_low;

	assign unl_p     = (op_q == OP_SEARCH) ? here_q : del_q;
	assign unl_kind  = prev_rd_q[PREV_W-1 -: 2];
	assign cmp_mism  = (win_rd_a_q != win_rd_b_q);
	assign init_w    = clamp_win(ws_q);
	assign init_l    = clamp_len(ml_q, init_w);
	assign clr_low   = (clr_q < HASH_W'(WinMax));

	// Candidate offset and clipped length; a candidate needs its first four bytes equal
	always_comb begin
		if (ins_q <= here_q) begin
			eval_ofs = w_q + WSZ_W'(ins_q) - WSZ_W'(here_q);
		end else begin
			eval_ofs = WSZ_W'(ins_q) - WSZ_W'(here_q);
		end
		eval_len  = (eval_ofs <= WSZ_W'(len_q)) ? eval_ofs[LEN_W-1:0] : len_q;
		eval_take = (len_q >= LEN_W'(4)) && (len_q > best_q) && (eval_len > best_q);
	end

	// Status to the controller
	always_comb begin
		sts.op         = op_q;
		sts.reg_pos    = reg_q;
		sts.hash_done  = (hk_q == 3'd4);
		sts.clr_last   = &clr_q;
		sts.unl_linked = (unl_kind != KIND_NONE);
		sts.unl_has    = next_rd_q[LINK_W-1];
		sts.chain_end  = !cur_v_q || (steps_q == WSZ_W'(WinMax));
		sts.cmp_done   = pend_q && (cmp_mism || (k_q == l_q));
		sts.eval_full  = eval_take && (eval_len >= l_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Memory port selection per micro-op
	always_comb begin
		win_we   = 1'b0;
		win_wa   = del_q;
		win_wd   = byte_q;
		win_ra_a = (cmd.uop == UOP_HASH) ? ring_add(ins_q, LEN_W'(hk_q), w_q)
			: ring_add(here_q, k_q, w_q);
		win_ra_b = ring_add(ins_q, k_q, w_q);
		head_we  = 1'b0;
		head_re  = 1'b0;
		head_wa  = h_q;
		head_wd  = next_rd_q;
		next_we  = 1'b0;
		next_re  = 1'b0;
		next_wa  = unl_p;
		next_ra  = unl_p;
		next_wd  = next_rd_q;
		prev_we  = 1'b0;
		prev_re  = 1'b0;
		prev_wa  = unl_p;
		prev_wd  = '0;
		case (cmd.uop)
			UOP_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
				head_wd = '0;
				next_we = clr_low;
				next_wa = clr_q[POS_W-1:0];
				next_wd = '0;
				prev_we = clr_low;
				prev_wa = clr_q[POS_W-1:0];
			end
			UOP_PRELOAD: begin
				win_we = (pre_q < l_q);
				win_wa = ring_add(ins_q, pre_q, w_q);
			end
			UOP_UNL_RD: begin
				next_re = 1'b1;
				prev_re = 1'b1;
			end
			UOP_UNL_WR1: begin
				// drop p from its chain: predecessor takes over p's successor
				prev_we = sts.unl_linked;
				prev_wd = {KIND_NONE, HASH_W'(0)};
				if (unl_kind == KIND_HEAD) begin
					head_we = 1'b1;
					head_wa = prev_rd_q[HASH_W-1:0];
				end else if (unl_kind != KIND_NONE) begin
					next_we = 1'b1;
					next_wa = prev_rd_q[POS_W-1:0];
				end
			end
			UOP_UNL_WR2: begin
				next_we = 1'b1;
				next_wd = {1'b0, next_rd_q[POS_W-1:0]};
				prev_we = 1'b1;
				prev_wa = next_rd_q[POS_W-1:0];
				prev_wd = prev_rd_q;
			end
			UOP_WBYTE: begin
				win_we = 1'b1;
			end
			UOP_HEAD_RD: begin
				head_re = 1'b1;
			end
			UOP_LINK1: begin
				head_we = 1'b1;
				head_wd = {1'b1, ins_q};
				prev_we = 1'b1;
				prev_wa = ins_q;
				prev_wd = {KIND_HEAD, h_q};
				next_we = 1'b1;
				next_wa = ins_q;
				next_wd = head_rd_q;
			end
			UOP_LINK2: begin
				prev_we = head_rd_q[LINK_W-1];
				prev_wa = head_rd_q[POS_W-1:0];
				prev_wd = {KIND_NODE, HASH_W'(ins_q)};
			end
			UOP_S_NEXT: begin
				next_re = 1'b1;
				next_ra = cur_q;
			end
			default: begin
			end
		endcase
	end

	// Memory arrays with registered reads
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wa] <= win_wd;
		end
		win_rd_a_q <= win_mem[win_ra_a];
		win_rd_b_q <= win_mem[win_ra_b];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		if (head_re) begin
			head_rd_q <= head_mem[h_q];
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (next_re) begin
			next_rd_q <= next_mem[next_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (prev_re) begin
			prev_rd_q <= prev_mem[unl_p];
		end
	end

	// Configuration, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WSZ_W'(WinMax);
			ml_q        <= LEN_W'(18);
			w_q         <= WSZ_W'(WinMax);
			l_q         <= LEN_W'(18);
			ins_q       <= POS_W'(WinMax - 18);
			del_q       <= '0;
			pre_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WINDOW) begin
					ws_q <= cfg_data;
				end else begin
					ml_q <= cfg_data[LEN_W-1:0];
				end
			end
			case (cmd.uop)
				UOP_INIT: begin
					w_q   <= init_w;
					l_q   <= init_l;
					ins_q <= POS_W'(init_w - WSZ_W'(init_l));
					del_q <= '0;
					pre_q <= '0;
					clr_q <= '0;
				end
				UOP_CLEAR: begin
					clr_q <= clr_q + HASH_W'(1);
				end
				UOP_PRELOAD: begin
					if (pre_q < l_q) begin
						pre_q <= pre_q + LEN_W'(1);
					end
				end
				UOP_STEP: begin
					del_q <= (WSZ_W'(del_q) + WSZ_W'(1) >= w_q) ? '0 : del_q + POS_W'(1);
					ins_q <= (WSZ_W'(ins_q) + WSZ_W'(1) >= w_q) ? '0 : ins_q + POS_W'(1);
				end
				default: begin
				end
			endcase
			if (cmd.uop == UOP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction, hash, walk and compare registers
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LATCH: begin
				op_q   <= op;
				byte_q <= data_byte;
				reg_q  <= register_position;
				hk_q   <= '0;
				h_q    <= '0;
				best_q <= '0;
				bo_q   <= '0;
			end
			UOP_HASH: begin
				if (hk_q != 3'd0) begin
					h_q <= h_q ^ hash_term(2'(hk_q - 3'd1), win_rd_a_q);
				end
				hk_q <= hk_q + 3'd1;
			end
			UOP_S_START: begin
				cur_q   <= head_rd_q[POS_W-1:0];
				cur_v_q <= head_rd_q[LINK_W-1];
				steps_q <= '0;
			end
			UOP_S_NEXT: begin
				here_q  <= cur_q;
				steps_q <= steps_q + WSZ_W'(1);
			end
			UOP_S_CAP: begin
				cur_q   <= next_rd_q[POS_W-1:0];
				cur_v_q <= next_rd_q[LINK_W-1];
				k_q     <= '0;
				pend_q  <= 1'b0;
			end
			UOP_CMP: begin
				// compare the byte pair read last cycle, issue the next pair
				if (pend_q && cmp_mism) begin
					len_q <= k_q - LEN_W'(1);
				end else if (pend_q && (k_q == l_q)) begin
					len_q <= l_q;
				end else begin
					k_q    <= k_q + LEN_W'(1);
					pend_q <= 1'b1;
				end
			end
			UOP_EVAL: begin
				if (eval_take) begin
					best_q <= (eval_len >= l_q) ? l_q : eval_len;
					bo_q   <= eval_ofs;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.uop == UOP_LOAD_OUT) begin
			out_len_q <= best_q;
			out_ofs_q <= bo_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_length = out_len_q;
	assign match_offset = out_ofs_q;

endmodule

### rtl/core/lzss_hash_chain_match_finder.sv
// LZSS hash chain match finder, top level.
// Joins lzss_hmf_ctl and lzss_hmf_dp; uses lzss_hmf_pkg.
//
// One transaction in gives one result out. An advance unlinks the oldest
// position and, when the position is registered, hashes four window reads and
// updates the chain head. A search walks the chain and compares byte pairs for
// each entry visited (one byte pair per cycle from a dual read window port),
// and unlinks the matched position when a full-length match ends the walk.
// The walk visits at most 4096 entries. A dictionary reset and the reset pin
// both run a clearing pass over all 32768 chain head entries, which also clears
// the next and previous link memories, one entry per cycle; no transaction is
// taken during it, configuration writes are. Window and length registers take
// effect at each dictionary reset; the reset pin sets them to 4096 and 18.
module lzss_hash_chain_match_finder
	import lzss_hmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WSZ_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        data_byte,
	input  logic              register_position,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LEN_W-1:0]  match_length,
	output logic [WSZ_W-1:0]  match_offset
);

	ctl_cmd_t   cmd;
	dp_status_t sts;

	lzss_hmf_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzss_hmf_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.op                (op),
		.data_byte         (data_byte),
		.register_position (register_position),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.match_length      (match_length),
		.match_offset      (match_offset)
	);

endmodule
